### hdl/dqsc_pkg.sv
// Shared types, constants and table functions for the dual quadrature step counter.
`timescale 1ns / 1ps
`default_nettype none

package dqsc_pkg;

    // Number of tracked encoders (1..4); only the first two have pins
    localparam int NUM_ENCODERS = 2;
    localparam int PIN_ENCODERS = 2;

    localparam int PINS_W  = 4;
    localparam int BTN_W   = 2;
    localparam int COUNT_W = 10;
    localparam int TREND_W = 8;
    localparam int STEP_W  = 3;
    localparam int SUM_W   = 12;

    localparam logic [COUNT_W-1:0] WRAP_RESET = 10'd1023;

    localparam logic [1:0]         DETENT     = 2'b11;
    localparam logic [TREND_W-1:0] CW_LOW     = 8'd2;
    localparam logic [TREND_W-1:0] CW_LIMIT   = 8'd100;
    localparam logic [TREND_W-1:0] CCW_FLOOR  = 8'h90;

    // Direction codes (also the report codes on the outputs)
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // Step mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_STEP1 = 2'd1;
    localparam logic [1:0] MODE_STEP2 = 2'd2;
    localparam logic [1:0] MODE_STEP4 = 2'd3;

    // Button codes
    localparam logic [1:0] BTN_IDLE = 2'd0;
    localparam logic [1:0] BTN_ZERO = 2'd1;
    localparam logic [1:0] BTN_ONE  = 2'd2;
    localparam logic [1:0] BTN_BOTH = 2'd3;

    typedef logic [1:0] t_dir;
    typedef t_dir [NUM_ENCODERS-1:0] t_dir_vec;

    // Lane reports handed to the merge stage
    typedef struct packed {
        logic     en;
        t_dir_vec reports;
    } t_lane_out;

    // Direction from {previous pins, current pins}
    function automatic t_dir dir_lookup(input logic [3:0] idx);
        t_dir d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_CW;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_CCW;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

    // Step size held by each mode
    function automatic logic [STEP_W-1:0] step_of_mode(input logic [1:0] mode);
        logic [STEP_W-1:0] s;
        case (mode)
            MODE_NONE:  s = 3'd0;
            MODE_STEP1: s = 3'd1;
            MODE_STEP2: s = 3'd2;
            MODE_STEP4: s = 3'd4;
            default:    s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/dqsc_lane.sv
// One encoder lane: pin history, trend counter and detent report.
`timescale 1ns / 1ps
`default_nettype none

module dqsc_lane (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [1:0]       i_pins,
    output dqsc_pkg::t_dir        o_report
);

    logic [1:0]                   r_hist;
    logic [dqsc_pkg::TREND_W-1:0] r_trend;
    logic [1:0]                   n_hist;
    logic [dqsc_pkg::TREND_W-1:0] n_trend;
    logic [dqsc_pkg::TREND_W-1:0] trend_mv;
    dqsc_pkg::t_dir               step_dir;

    // Move trend by the table direction, then judge it at the detent
    always_comb begin
        step_dir = dqsc_pkg::dir_lookup({r_hist, i_pins});
        case (step_dir)
            dqsc_pkg::DIR_CW:  trend_mv = r_trend + 8'd1;
            dqsc_pkg::DIR_CCW: trend_mv = r_trend - 8'd1;
            default:           trend_mv = r_trend;
        endcase
        o_report = dqsc_pkg::DIR_NONE;
        n_trend  = trend_mv;
        if (i_pins == dqsc_pkg::DETENT) begin
            if (trend_mv > dqsc_pkg::CCW_FLOOR) begin
                o_report = dqsc_pkg::DIR_CCW;
            end else if (trend_mv >= dqsc_pkg::CW_LOW && trend_mv < dqsc_pkg::CW_LIMIT) begin
                o_report = dqsc_pkg::DIR_CW;
            end
            n_trend = '0;
        end
        n_hist = i_pins;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_trend <= '0;
        end else if (i_en) begin
            r_hist  <= n_hist;
            r_trend <= n_trend;
        end
    end

endmodule

`default_nettype wire

### hdl/dqsc_merge.sv
// Merge stage: sums lane reports into the position, folds it, tracks step mode.
`timescale 1ns / 1ps
`default_nettype none

module dqsc_merge (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dqsc_pkg::t_lane_out             i_lanes,
    input  wire logic [dqsc_pkg::BTN_W-1:0]      i_buttons,
    input  wire logic [dqsc_pkg::COUNT_W-1:0]    i_wrap,
    output logic [dqsc_pkg::COUNT_W-1:0]         o_count,
    output logic [1:0]                           o_mode
);

    logic [dqsc_pkg::COUNT_W-1:0] r_pos;
    logic [1:0]                   r_mode;
    logic [dqsc_pkg::STEP_W-1:0]  r_step;
    logic [dqsc_pkg::COUNT_W-1:0] n_pos;
    logic [1:0]                   n_mode;
    logic signed [dqsc_pkg::SUM_W-1:0] sum;
    logic signed [dqsc_pkg::SUM_W-1:0] step_s;
    logic signed [dqsc_pkg::SUM_W-1:0] wrap_s;
    logic signed [dqsc_pkg::SUM_W-1:0] folded;

    // Sum all lane moves, then fold once into 0..wrap
    always_comb begin
        step_s = $signed({{(dqsc_pkg::SUM_W - dqsc_pkg::STEP_W){1'b0}}, r_step});
        wrap_s = $signed({{(dqsc_pkg::SUM_W - dqsc_pkg::COUNT_W){1'b0}}, i_wrap});
        sum    = $signed({{(dqsc_pkg::SUM_W - dqsc_pkg::COUNT_W){1'b0}}, r_pos});
        for (int e = 0; e < dqsc_pkg::NUM_ENCODERS; e++) begin
            if (i_lanes.reports[e] == dqsc_pkg::DIR_CW) begin
                sum = sum + step_s;
            end else if (i_lanes.reports[e] == dqsc_pkg::DIR_CCW) begin
                sum = sum - step_s;
            end
        end
        if (sum < 0) begin
            folded = sum + wrap_s;
        end else if (sum > wrap_s) begin
            folded = sum - wrap_s;
        end else begin
            folded = sum;
        end
        n_pos = folded[dqsc_pkg::COUNT_W-1:0];
    end

    // Mode follows the buttons; mode none sticks while no button is set
    always_comb begin
        case (i_buttons)
            dqsc_pkg::BTN_BOTH: n_mode = dqsc_pkg::MODE_NONE;
            dqsc_pkg::BTN_ONE:  n_mode = dqsc_pkg::MODE_STEP4;
            dqsc_pkg::BTN_ZERO: n_mode = dqsc_pkg::MODE_STEP2;
            default: begin
                n_mode = (r_mode == dqsc_pkg::MODE_NONE) ? dqsc_pkg::MODE_NONE
                                                         : dqsc_pkg::MODE_STEP1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= dqsc_pkg::MODE_STEP1;
            r_step <= 3'd1;
        end else if (i_lanes.en) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
            r_step <= dqsc_pkg::step_of_mode(r_mode);
        end
    end

    assign o_count = n_pos;
    assign o_mode  = n_mode;

`ifndef NO_ASSERTIONS
    // Mode none holds while the buttons stay clear
    a_none_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lanes.en && r_mode == dqsc_pkg::MODE_NONE && i_buttons == dqsc_pkg::BTN_IDLE)
        |=> (r_mode == dqsc_pkg::MODE_NONE))
        else $error("step mode left none without a button");

    // Step size lags the mode by one request
    a_step_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lanes.en |=> (r_step == dqsc_pkg::step_of_mode($past(r_mode))))
        else $error("step size does not follow previous mode");

    // Position moves only on an accepted request
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_lanes.en |=> $stable(r_pos))
        else $error("position changed without a request");
`endif

endmodule

`default_nettype wire

### hdl/dual_quadrature_step_counter_core.sv
// Top level: encoder lanes, merge stage, wrap register and output register.
// An accepted request's result is written to the output register and shown from the next edge.
// Throughput: one request per cycle; the single output register decides acceptance, which
// continues while no result is held or the held result is taken in the same cycle.
// Reset (synchronous, active low): pin history and trends zero, mode step1,
// step size one, position zero, wrap 1023, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module dual_quadrature_step_counter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [dqsc_pkg::PINS_W-1:0]     i_enc_pins,
    input  wire logic [dqsc_pkg::BTN_W-1:0]      i_buttons,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [dqsc_pkg::COUNT_W-1:0]         o_count,
    output logic [1:0]                           o_dir_zero,
    output logic [1:0]                           o_dir_one,
    output logic [1:0]                           o_step_mode,
    input  wire logic                            i_cfg_we,
    input  wire logic [dqsc_pkg::COUNT_W-1:0]    i_cfg_wdata
);

    logic [dqsc_pkg::COUNT_W-1:0] r_wrap;
    logic                         r_out_valid;
    logic [dqsc_pkg::COUNT_W-1:0] r_count;
    logic [1:0]                   r_dir_zero;
    logic [1:0]                   r_dir_one;
    logic [1:0]                   r_mode_out;
    logic                         accept;
    dqsc_pkg::t_lane_out          lanes;
    logic [dqsc_pkg::COUNT_W-1:0] n_count;
    logic [1:0]                   n_mode;
    logic [1:0]                   n_dir_one;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign lanes.en   = accept;

    // One lane per encoder; lanes beyond the pins see 00
    for (genvar e = 0; e < dqsc_pkg::NUM_ENCODERS; e++) begin : g_lane
        logic [1:0] pins;
        if (e < dqsc_pkg::PIN_ENCODERS) begin : g_pins
            assign pins = i_enc_pins[2*e +: 2];
        end else begin : g_nopins
            assign pins = 2'b00;
        end
        dqsc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (accept),
            .i_pins   (pins),
            .o_report (lanes.reports[e])
        );
    end

    if (dqsc_pkg::NUM_ENCODERS > 1) begin : g_dir_one
        assign n_dir_one = lanes.reports[1];
    end else begin : g_no_dir_one
        assign n_dir_one = dqsc_pkg::DIR_NONE;
    end

    dqsc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lanes   (lanes),
        .i_buttons (i_buttons),
        .i_wrap    (r_wrap),
        .o_count   (n_count),
        .o_mode    (n_mode)
    );

    // Wrap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= dqsc_pkg::WRAP_RESET;
        end else if (i_cfg_we) begin
            r_wrap <= i_cfg_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_count    <= n_count;
            r_dir_zero <= lanes.reports[0];
            r_dir_one  <= n_dir_one;
            r_mode_out <= n_mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;
    assign o_dir_zero  = r_dir_zero;
    assign o_dir_one   = r_dir_one;
    assign o_step_mode = r_mode_out;

`ifndef NO_ASSERTIONS
    // Every accepted request leaves a result pending
    a_result_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

    // A report is never both directions
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_dir_zero != 2'b11 && r_dir_one != 2'b11))
        else $error("illegal direction code");

    // Held result is not overwritten while waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !accept)
        else $error("request accepted over a pending result");
`endif

endmodule

`default_nettype wire
